/* design/assert_macros.svh */
// Assertion helpers shared by the RTL of the crab steering block.
// Each macro takes a label, the clock, the synchronous reset and the
// expression to check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define CSV_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CSV_ASSERT(lbl, clk, rst, prop)
`define CSV_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* design/csv_pkg.sv */
package csv_pkg;

  // Field widths.
  localparam int VelW   = 16;
  localparam int AngW   = 16;
  localparam int DbW    = 15;

  // Default number of CORDIC rotations and the length of the arctangent table.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int AtanEntries       = 24;

  // Square root: a 32-bit radicand yields one result bit per digit step.
  localparam int SqrtDigits = 16;
  localparam int RadW       = 32;
  localparam int RemW       = 19;
  localparam int RootW      = 16;

  // CORDIC datapath: inputs are scaled by 2^8, the angle is Q2.29.
  localparam int Prescale = 8;
  localparam int CxW      = 27;
  localparam int ZW       = 32;
  localparam int SumW     = 34;

  localparam logic signed [SumW-1:0] PiQ29     = 34'sd1686629713;
  localparam logic signed [SumW-1:0] RoundHalf = 34'sd32768;
  localparam logic signed [AngW+1:0] AngLimit  = 18'sd25736;

  // Arctangent of 2^-i in Q2.29, rounded to nearest.
  localparam logic [ZW-1:0] ATAN_Q29 [AtanEntries] = '{
    32'd421657428, 32'd248918915, 32'd131521918, 32'd66762579,
    32'd33510843,  32'd16771758,  32'd8387925,   32'd4194219,
    32'd2097141,   32'd1048575,   32'd524288,    32'd262144,
    32'd131072,    32'd65536,     32'd32768,     32'd16384,
    32'd8192,      32'd4096,      32'd2048,      32'd1024,
    32'd512,       32'd256,       32'd128,       32'd64
  };

  typedef enum logic [1:0] {
    MODE_STOP     = 2'd0,
    MODE_CRAB     = 2'd1,
    MODE_STRAIGHT = 2'd2
  } mode_t;

  // Payload that travels down the row of cells.
  typedef struct packed {
    logic signed [CxW-1:0]  cx;
    logic signed [CxW-1:0]  cy;
    logic signed [ZW-1:0]   z;
    logic        [RadW-1:0] rad;
    logic        [RemW-1:0] rem;
    logic        [RootW-1:0] root;
    logic signed [VelW-1:0] x;
    logic        [VelW-1:0] ay;
    logic                   yneg;
    logic                   zero;
  } cell_t;

  // One finished result beat.
  typedef struct packed {
    mode_t                  mode;
    logic signed [AngW-1:0] angle;
    logic signed [VelW-1:0] speed;
  } res_t;

endpackage

/* design/csv_front.sv */
module csv_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2*csv_pkg::VelW-1:0] in_data,
  output logic                   out_valid,
  output csv_pkg::cell_t         out_cell
);

  logic                          v1;
  logic signed [csv_pkg::VelW-1:0] x1;
  logic signed [csv_pkg::VelW-1:0] y1;
  logic        [csv_pkg::VelW-1:0] ax1;
  logic        [csv_pkg::VelW-1:0] ay1;
  logic        [csv_pkg::RadW-2:0] ax2;
  logic        [csv_pkg::RadW-2:0] ay2;

  logic signed [csv_pkg::VelW-1:0] x_in;
  logic signed [csv_pkg::VelW-1:0] y_in;
  logic        [csv_pkg::VelW-1:0] ax_in;
  logic        [csv_pkg::VelW-1:0] ay_in;
  logic        [2*csv_pkg::VelW-1:0] ax_sq;
  logic        [2*csv_pkg::VelW-1:0] ay_sq;
  logic        [csv_pkg::RadW:0]   sq_sum;

  // Absolute values; the most negative input maps to 2^15, which fits unsigned.
  always_comb begin
    x_in  = in_data[csv_pkg::VelW-1:0];
    y_in  = in_data[2*csv_pkg::VelW-1:csv_pkg::VelW];
    ax_in = x_in[csv_pkg::VelW-1] ? (~x_in + 1'b1) : x_in;
    ay_in = y_in[csv_pkg::VelW-1] ? (~y_in + 1'b1) : y_in;
    ax_sq = ax_in * ax_in;
    ay_sq = ay_in * ay_in;
  end

  // First stage: squares of both components.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= x_in;
      y1  <= y_in;
      ax1 <= ax_in;
      ay1 <= ay_in;
      ax2 <= ax_sq[csv_pkg::RadW-2:0];
      ay2 <= ay_sq[csv_pkg::RadW-2:0];
    end
  end

  assign sq_sum = {2'b00, ax2} + {2'b00, ay2};

  // Second stage: radicand and the prescaled CORDIC start vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cell.cx   <= {3'b000, ax1, {csv_pkg::Prescale{1'b0}}};
      out_cell.cy   <= {{3{y1[csv_pkg::VelW-1]}}, y1, {csv_pkg::Prescale{1'b0}}};
      out_cell.z    <= '0;
      out_cell.rad  <= sq_sum[csv_pkg::RadW-1:0];
      out_cell.rem  <= '0;
      out_cell.root <= '0;
      out_cell.x    <= x1;
      out_cell.ay   <= ay1;
      out_cell.yneg <= y1[csv_pkg::VelW-1];
      out_cell.zero <= (x1 == '0) && (y1 == '0);
    end
  end

endmodule

/* design/csv_cell.sv */
module csv_cell #(
  parameter int STEP          = 0,
  parameter int CORDIC_STAGES = csv_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  csv_pkg::cell_t in_cell,
  output logic           out_valid,
  output csv_pkg::cell_t out_cell
);

  localparam bit DoCordic = (STEP < CORDIC_STAGES);
  localparam bit DoSqrt   = (STEP < csv_pkg::SqrtDigits);

  logic signed [csv_pkg::CxW-1:0]  dx;
  logic signed [csv_pkg::CxW-1:0]  dy;
  logic signed [csv_pkg::ZW-1:0]   atan_step;
  logic        [csv_pkg::RemW-1:0] rem_sh;
  logic        [csv_pkg::RemW-1:0] trial;
  logic                            take;
  csv_pkg::cell_t                  cell_next;

  always_comb begin
    dx        = in_cell.cy >>> STEP;
    dy        = in_cell.cx >>> STEP;
    atan_step = $signed(csv_pkg::ATAN_Q29[STEP]);
    // One square root digit: bring down two radicand bits, try 4*root+1.
    rem_sh    = {in_cell.rem[csv_pkg::RemW-3:0],
                 in_cell.rad[csv_pkg::RadW-1:csv_pkg::RadW-2]};
    trial     = {1'b0, in_cell.root, 2'b01};
    take      = (rem_sh >= trial);

    cell_next = in_cell;
    // One CORDIC vectoring rotation, driving cy toward zero.
    if (DoCordic) begin
      if (!in_cell.cy[csv_pkg::CxW-1]) begin
        cell_next.cx = in_cell.cx + dx;
        cell_next.cy = in_cell.cy - dy;
        cell_next.z  = in_cell.z + atan_step;
      end else begin
        cell_next.cx = in_cell.cx - dx;
        cell_next.cy = in_cell.cy + dy;
        cell_next.z  = in_cell.z - atan_step;
      end
    end
    if (DoSqrt) begin
      cell_next.rad  = {in_cell.rad[csv_pkg::RadW-3:0], 2'b00};
      cell_next.rem  = take ? (rem_sh - trial) : rem_sh;
      cell_next.root = {in_cell.root[csv_pkg::RootW-2:0], take};
    end
  end

  // Hand the updated beat to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cell <= cell_next;
    end
  end

endmodule

/* design/csv_back.sv */
`include "assert_macros.svh"

module csv_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  csv_pkg::cell_t            in_cell,
  input  logic [csv_pkg::DbW-1:0]   deadband,
  output logic                      en,
  output logic                      out_valid,
  input  logic                      out_ready,
  output csv_pkg::res_t             out_res
);

  logic                              spare_valid;
  csv_pkg::res_t                     spare;
  csv_pkg::res_t                     res_next;
  logic signed [csv_pkg::ZW-1:0]     phi;
  logic signed [csv_pkg::SumW-1:0]   fold;
  logic signed [csv_pkg::SumW-1:0]   sum;
  logic signed [csv_pkg::AngW+1:0]   ang_full;
  logic signed [csv_pkg::AngW-1:0]   ang_clamp;
  logic        [csv_pkg::DbW-1:0]    mag;
  logic signed [csv_pkg::VelW-1:0]   mag_s;
  logic                              xneg;
  logic                              take;
  logic                              in_beat;

  // Fold the angle by pi for negative x, round to Q3.13 and clamp.
  always_comb begin
    xneg = in_cell.x[csv_pkg::VelW-1];
    phi  = in_cell.zero ? '0 : in_cell.z;
    if (xneg && !in_cell.yneg) begin
      fold = csv_pkg::RoundHalf - csv_pkg::PiQ29;
    end else if (xneg) begin
      fold = csv_pkg::RoundHalf + csv_pkg::PiQ29;
    end else begin
      fold = csv_pkg::RoundHalf;
    end
    sum      = csv_pkg::SumW'(phi) + fold;
    ang_full = sum[csv_pkg::SumW-1:16];
    if (ang_full > csv_pkg::AngLimit) begin
      ang_clamp = csv_pkg::AngW'(csv_pkg::AngLimit);
    end else if (ang_full < -csv_pkg::AngLimit) begin
      ang_clamp = csv_pkg::AngW'(-csv_pkg::AngLimit);
    end else begin
      ang_clamp = ang_full[csv_pkg::AngW-1:0];
    end
  end

  // Saturated magnitude and the choice between stop, crab and straight drive.
  always_comb begin
    mag   = in_cell.root[csv_pkg::RootW-1] ? '1 : in_cell.root[csv_pkg::DbW-1:0];
    mag_s = {1'b0, mag};
    res_next.angle = ang_clamp;
    if (mag < deadband) begin
      res_next.speed = '0;
      res_next.mode  = csv_pkg::MODE_STOP;
    end else if (in_cell.ay >= {1'b0, deadband}) begin
      res_next.speed = xneg ? -mag_s : mag_s;
      res_next.mode  = csv_pkg::MODE_CRAB;
    end else begin
      res_next.speed = in_cell.x;
      res_next.angle = '0;
      res_next.mode  = csv_pkg::MODE_STRAIGHT;
    end
  end

  // The row of cells moves whenever the spare register is free.
  assign en      = !spare_valid;
  assign take    = out_valid && out_ready;
  assign in_beat = in_valid && en;

  // Output register with one spare entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (take) begin
        spare_valid <= 1'b0;
      end
    end else if (in_beat) begin
      if (out_valid && !take) begin
        spare_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid) begin
      if (take) begin
        out_res <= spare;
      end
    end else if (in_beat) begin
      if (out_valid && !take) begin
        spare <= res_next;
      end else begin
        out_res <= res_next;
      end
    end
  end

  `CSV_ASSERT(a_spare_behind_out, clk, rst, spare_valid |-> out_valid)
  `CSV_ASSERT(a_spare_moves_up, clk, rst, (spare_valid && take) |=> out_valid)
  `CSV_ASSERT(a_stall_fills_spare, clk, rst,
              (in_beat && out_valid && !out_ready) |=> spare_valid)
  `CSV_NEVER(a_angle_in_range, clk, rst,
             out_valid && ((out_res.angle > 16'sd25736) || (out_res.angle < -16'sd25736)))
  `CSV_NEVER(a_straight_no_angle, clk, rst,
             out_valid && (out_res.mode == csv_pkg::MODE_STRAIGHT) && (out_res.angle != '0))

endmodule

/* design/crab_steer_vector_to_wheel.sv */
// Crab steering: one planar velocity command in, one wheel command out.
//
// Slave channel: each beat carries lin_x and lin_y (signed Q4.12). Master
// channel: each beat carries wheel_speed (Q4.12), wheel_angle (Q3.13 radians)
// and drive_mode in tuser (stopped, crab, straight). The user must write the
// deadband register (cfg_we / cfg_wdata) with no beat in flight, unenforced.
//
// From input beat to output beat a command passes two front stages (squares,
// then radicand sum), one cell per CORDIC rotation or square root digit, and
// the output register. Throughput is one beat per cycle while s_axis_tready
// is high; every cell takes a new beat each clock unless the row is held.
//
// Reset clears all valid bits and loads the deadband with 41 (about 0.01).
// When the receiver stalls, the output register holds its beat and one more
// finished beat lands in a spare register; only then does s_axis_tready
// drop and the whole row of cells hold. s_axis_tready is a register output.
module crab_steer_vector_to_wheel #(
  parameter int CORDIC_STAGES = csv_pkg::CORDIC_STAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [csv_pkg::DbW-1:0]   cfg_wdata,     // vel_deadband
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,  // lin_x, lin_y
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,  // wheel_speed, wheel_angle
  output logic [1:0]                m_axis_tuser   // drive_mode
);

  localparam int NumCells = (CORDIC_STAGES > csv_pkg::SqrtDigits) ?
                            CORDIC_STAGES : csv_pkg::SqrtDigits;

  logic                      en;
  logic [csv_pkg::DbW-1:0]   deadband;
  logic                      valid [NumCells+1];
  csv_pkg::cell_t            cells [NumCells+1];
  csv_pkg::res_t             res;

  // Deadband register.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= csv_pkg::DbW'(41);
    end else if (cfg_we) begin
      deadband <= cfg_wdata;
    end
  end

  assign s_axis_tready = en;

  csv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .out_valid (valid[0]),
    .out_cell  (cells[0])
  );

  // Row of cells: CORDIC rotations and square root digits side by side.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    csv_cell #(
      .STEP          (i),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (valid[i]),
      .in_cell   (cells[i]),
      .out_valid (valid[i+1]),
      .out_cell  (cells[i+1])
    );
  end

  csv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[NumCells]),
    .in_cell   (cells[NumCells]),
    .deadband  (deadband),
    .en        (en),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {res.angle, res.speed};
  assign m_axis_tuser = res.mode;

endmodule

/* verif/tb_top.sv */
module tb_top;

  localparam int Stages = csv_pkg::CORDIC_STAGES_DEF;

  // Arctangent of 2^-i in Q2.29, rounded to nearest.
  localparam longint ArcTanQ29 [24] = '{
    421657428, 248918915, 131521918, 66762579,
    33510843,  16771758,  8387925,   4194219,
    2097141,   1048575,   524288,    262144,
    131072,    65536,     32768,     16384,
    8192,      4096,      2048,      1024,
    512,       256,       128,       64
  };
  localparam longint PiQ29Ref = 1686629713;

  // Directed commands: field extremes, the boundaries of the stop, crab and
  // straight regions at the reset deadband, and the zero and negative-x axes.
  localparam int DirX [24] = '{
    0, -1, -32768, 32767, 0, 0, 32767, -32768, -32768, 32767, 10, -20,
    40, 41, -41, 1000, 1000, 1000, -1000, -1000, -4096, 0, 0, 29
  };
  localparam int DirY [24] = '{
    0, 0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 10, 30,
    0, 0, 0, 40, 41, -41, 1000, -1000, -1, 41, -41, 29
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [14:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;    // lin_x, lin_y
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;    // wheel_speed, wheel_angle
  logic [1:0]  m_axis_tuser;    // drive_mode
  logic        no_idle;

  // Tracks the wheel commands the block owes and checks each output beat.
  class wheel_cmd_scoreboard;
    logic [14:0]   deadband;
    csv_pkg::res_t awaited_wheel_cmds [$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   n_stop, n_crab, n_straight;

    function new();
      deadband = 15'd41;
      errors = 0;
      checked = 0;
      n_stop = 0;
      n_crab = 0;
      n_straight = 0;
    endfunction

    function int pending();
      return awaited_wheel_cmds.size();
    endfunction

    // Speed, steering angle and mode for one velocity command.
    function csv_pkg::res_t wheel_command(logic signed [15:0] lin_x,
                                          logic signed [15:0] lin_y);
      csv_pkg::res_t r;
      longint xs, ys, ax, ay, db;
      longint rem, root, bitv, mag;
      longint cx, cy, z, dx, dy, ang;
      xs = lin_x;
      ys = lin_y;
      db = deadband;
      ax = (xs < 0) ? -xs : xs;
      ay = (ys < 0) ? -ys : ys;

      // Integer square root of x^2 + y^2, bit by bit.
      rem = ax * ax + ay * ay;
      root = 0;
      bitv = longint'(1) << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      mag = (root > 32767) ? 32767 : root;

      // Vectoring rotations on (|x|, y), scaled by 2^8.
      z = 0;
      if (ax != 0 || ys != 0) begin
        cx = ax * 256;
        cy = ys * 256;
        for (int i = 0; i < Stages && i < 24; i++) begin
          dx = cy >>> i;
          dy = cx >>> i;
          if (cy >= 0) begin
            cx = cx + dx;
            cy = cy - dy;
            z = z + ArcTanQ29[i];
          end else begin
            cx = cx - dx;
            cy = cy + dy;
            z = z - ArcTanQ29[i];
          end
        end
      end

      // Fold by pi for negative x, then round to Q3.13 and clamp.
      if (xs < 0) z = (ys >= 0) ? z - PiQ29Ref : z + PiQ29Ref;
      ang = (z + 32768) >>> 16;
      if (ang > 25736) ang = 25736;
      if (ang < -25736) ang = -25736;

      if (mag < db) begin
        r.speed = '0;
        r.angle = ang[15:0];
        r.mode = csv_pkg::MODE_STOP;
      end else if (ay >= db) begin
        r.speed = (xs >= 0) ? mag[15:0] : -mag[15:0];
        r.angle = ang[15:0];
        r.mode = csv_pkg::MODE_CRAB;
      end else begin
        r.speed = lin_x;
        r.angle = '0;
        r.mode = csv_pkg::MODE_STRAIGHT;
      end
      return r;
    endfunction

    function void note_command(logic signed [15:0] lin_x, logic signed [15:0] lin_y);
      csv_pkg::res_t r;
      r = wheel_command(lin_x, lin_y);
      case (r.mode)
        csv_pkg::MODE_STOP: n_stop++;
        csv_pkg::MODE_CRAB: n_crab++;
        default: n_straight++;
      endcase
      awaited_wheel_cmds.push_back(r);
    endfunction

    function void check_result(logic [31:0] data, logic [1:0] mode);
      csv_pkg::res_t      want;
      logic signed [15:0] speed, angle;
      speed = data[15:0];
      angle = data[31:16];
      if (awaited_wheel_cmds.size() == 0) begin
        $error("unexpected beat: wheel_speed %0d wheel_angle %0d drive_mode %0d",
               speed, angle, mode);
        errors++;
        return;
      end
      want = awaited_wheel_cmds.pop_front();
      checked++;
      if (speed !== want.speed) begin
        $error("wheel_speed: expected %0d, got %0d", want.speed, speed);
        errors++;
      end
      if (angle !== want.angle) begin
        $error("wheel_angle: expected %0d, got %0d", want.angle, angle);
        errors++;
      end
      if (mode !== want.mode) begin
        $error("drive_mode: expected %0d, got %0d", want.mode, mode);
        errors++;
      end
    endfunction
  endclass

  wheel_cmd_scoreboard sb;

  crab_steer_vector_to_wheel #(.CORDIC_STAGES(Stages)) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A velocity biased toward the deadband edges, small values and extremes.
  function automatic logic signed [15:0] pick_vel(int db);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
      4, 5, 6: begin
        v = db + int'($urandom_range(0, 16)) - 8;
        if ($urandom_range(0, 1)) v = -v;
      end
      7: v = int'($urandom_range(0, 128)) - 64;
      8: v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = 0;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // One command beat; holds tvalid high across back-to-back beats.
  task automatic send_cmd(input logic signed [15:0] lin_x, input logic signed [15:0] lin_y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {lin_y, lin_x};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every owed command has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_deadband(input logic [14:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.deadband = value;
  endtask

  // Accepted beats on both channels go to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_command(s_axis_tdata[15:0], s_axis_tdata[31:16]);
      end
    end
  end

  // Receiver: ready runs broken by random stalls.
  initial begin
    int run, gap;
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 24);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    #(20 * 400000);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    logic [14:0] db_list [7];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    no_idle = 1'b0;
    sb = new();
    // Reset value first, then both extremes, one, random settings and the reset value again.
    db_list = '{15'd41, 15'd0, 15'd32767, 15'd1, 15'($urandom_range(2, 200)),
                15'($urandom_range(0, 32767)), 15'd41};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < 24; k++) send_cmd(16'(DirX[k]), 16'(DirY[k]));

    for (int p = 0; p < 7; p++) begin
      if (p > 0) set_deadband(db_list[p]);
      no_idle = (p == 4);
      send_cmd(16'sd0, 16'sd0);
      send_cmd(16'sh8000, 16'sd0);
      for (int k = 0; k < 56; k++) begin
        if (p == 2 && k == 28) wait_drained();
        send_cmd(pick_vel(sb.deadband), pick_vel(sb.deadband));
      end
    end

    wait_drained();
    repeat (Stages + 8) @(posedge clk);
    $display("tb_top: %0d wheel commands checked over 7 deadband settings", sb.checked);
    $display("tb_top: modes seen: stop %0d, crab %0d, straight %0d",
             sb.n_stop, sb.n_crab, sb.n_straight);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* crab_steer_vector_to_wheel.f */
+incdir+design
design/csv_pkg.sv
design/csv_front.sv
design/csv_cell.sv
design/csv_back.sv
design/crab_steer_vector_to_wheel.sv
verif/tb_top.sv
